FILE: rtl/fawt_pkg.sv
// ----------------------------------------------------------------------------
// fawt_pkg: shared types and constants of the failed-attempt window tracker
// Holds table size defaults, register reset values and configuration indexes.
// ----------------------------------------------------------------------------
package fawt_pkg;

  localparam int DEF_TRACKED_ADDRESSES = 64;
  localparam int DEF_HISTORY_DEPTH     = 16;

  localparam logic [7:0]  LIMIT_RESET  = 8'd5;
  localparam logic [31:0] WINDOW_RESET = 32'd600;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAILURE_LIMIT = 8'd0,
    CFG_FIND_WINDOW   = 8'd1
  } cfg_reg_t;

  // Status of the back end as seen by the front end.
  typedef struct packed {
    logic clearing;
  } eng_status_t;

endpackage

FILE: rtl/fawt_ram.sv
// ----------------------------------------------------------------------------
// fawt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fawt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/fawt_queue.sv
// ----------------------------------------------------------------------------
// fawt_queue: two-entry request queue
// Holds accepted requests so the front end can take input while the engine works.
// ----------------------------------------------------------------------------
module fawt_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/fawt_engine.sv
// ----------------------------------------------------------------------------
// fawt_engine: table lookup, history update and failure count
// Scans the address table, walks the entry's history and produces one result.
// ----------------------------------------------------------------------------
module fawt_engine
  import fawt_pkg::*;
#(
  parameter int TRACKED_ADDRESSES = DEF_TRACKED_ADDRESSES,
  parameter int HISTORY_DEPTH     = DEF_HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [31:0] req_ip,
  input  logic [31:0] req_now,
  input  logic [7:0]  failure_limit,
  input  logic [31:0] find_window,
  output eng_status_t status,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        res_ban,
  output logic [8:0]  res_recent,
  output logic        res_dropped
);

  localparam int N   = TRACKED_ADDRESSES;
  localparam int D   = HISTORY_DEPTH;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int SW  = (D > 1) ? $clog2(D) : 1;
  localparam int FW  = $clog2(D + 1);
  localparam int KW  = FW + 33;
  localparam int TAW = (N * D > 1) ? $clog2(N * D) : 1;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_SCAN_RD = 9'b000000100,
    S_SCAN_CK = 9'b000001000,
    S_HIST_RD = 9'b000010000,
    S_HIST_PR = 9'b000100000,
    S_HIST_NW = 9'b001000000,
    S_COMMIT  = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   free_r, free_nxt;
  logic            have_free_r, have_free_nxt;
  logic [31:0]     ip_r, ip_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [TAW-1:0]  base_r, base_nxt;
  logic [SW-1:0]   src_r, src_nxt;
  logic [FW-1:0]   rem_r, rem_nxt;
  logic [FW-1:0]   kept_r, kept_nxt;
  logic [FW-1:0]   cnt_r, cnt_nxt;
  logic            filt_r, filt_nxt;
  logic            pend_ban_r, pend_ban_nxt;
  logic [8:0]      pend_cnt_r, pend_cnt_nxt;
  logic            pend_drop_r, pend_drop_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            oban_r, oban_nxt;
  logic [8:0]      ocnt_r, ocnt_nxt;
  logic            odrop_r, odrop_nxt;

  logic            key_we;
  logic [IW-1:0]   key_waddr, key_raddr;
  logic [KW-1:0]   key_wdata, key_rdata;
  logic            tm_we;
  logic [TAW-1:0]  tm_waddr, tm_raddr;
  logic [31:0]     tm_wdata, tm_rdata;

  logic [31:0]     elem;
  logic            elem_keep;
  logic            elem_counts;
  logic [FW-1:0]   ent_fill;
  logic            ent_valid;
  logic [31:0]     ent_key;
  logic            is_last;

  fawt_ram #(.WIDTH(KW), .DEPTH(N), .AW(IW)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (key_wdata),
    .rd_addr (key_raddr),
    .rd_data (key_rdata)
  );

  fawt_ram #(.WIDTH(32), .DEPTH(N * D), .AW(TAW)) u_time_ram (
    .clk     (clk),
    .wr_en   (tm_we),
    .wr_addr (tm_waddr),
    .wr_data (tm_wdata),
    .rd_addr (tm_raddr),
    .rd_data (tm_rdata)
  );

  assign ent_key   = key_rdata[31:0];
  assign ent_valid = key_rdata[32];
  assign ent_fill  = key_rdata[KW-1:33];
  assign is_last   = (idx_r == IW'(N - 1));

  // The element under process: a stored time, or the new time at the end.
  assign elem        = (state_r == S_HIST_NW) ? now_r : tm_rdata;
  assign elem_keep   = !filt_r || (elem >= (now_r - find_window));
  assign elem_counts = (find_window != 32'd0) && (elem <= now_r) &&
                       ((now_r - elem) <= find_window) &&
                       ({{(9 - FW){1'b0}}, cnt_r} <= {1'b0, failure_limit});

  assign key_raddr = idx_r;
  assign tm_raddr  = base_r + TAW'(src_r);
  assign tm_waddr  = base_r + TAW'(kept_r);
  assign tm_wdata  = elem;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    free_nxt      = free_r;
    have_free_nxt = have_free_r;
    ip_nxt        = ip_r;
    now_nxt       = now_r;
    base_nxt      = base_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    kept_nxt      = kept_r;
    cnt_nxt       = cnt_r;
    filt_nxt      = filt_r;
    pend_ban_nxt  = pend_ban_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_drop_nxt = pend_drop_r;
    ovalid_nxt    = ovalid_r && !res_ready;
    oban_nxt      = oban_r;
    ocnt_nxt      = ocnt_r;
    odrop_nxt     = odrop_r;
    key_we        = 1'b0;
    key_waddr     = idx_r;
    key_wdata     = '0;
    tm_we         = 1'b0;
    req_ready     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        key_we = 1'b1;
        idx_nxt = idx_r + IW'(1);
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ip_nxt        = req_ip;
          now_nxt       = req_now;
          idx_nxt       = '0;
          have_free_nxt = 1'b0;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (ent_valid && (ent_key == ip_r)) begin
          free_nxt  = idx_r;
          base_nxt  = TAW'(idx_r) * TAW'(D);
          filt_nxt  = (ent_fill == FW'(D)) && (find_window <= now_r);
          src_nxt   = (ent_fill == FW'(D)) ? SW'(1 % D) : '0;
          rem_nxt   = (ent_fill == FW'(D)) ? FW'(D - 1) : ent_fill;
          kept_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_HIST_RD;
        end else begin
          if (!ent_valid && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = idx_r;
          end
          if (is_last) begin
            if (have_free_r || !ent_valid) begin
              // A new address: empty history in the lowest free entry.
              base_nxt  = (have_free_r ? TAW'(free_r) : TAW'(idx_r)) * TAW'(D);
              filt_nxt  = 1'b0;
              src_nxt   = '0;
              rem_nxt   = '0;
              kept_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = S_HIST_RD;
            end else begin
              pend_ban_nxt  = 1'b0;
              pend_cnt_nxt  = '0;
              pend_drop_nxt = 1'b1;
              state_nxt     = S_OUT;
            end
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_HIST_RD: begin
        state_nxt = (rem_r == '0) ? S_HIST_NW : S_HIST_PR;
      end
      S_HIST_PR, S_HIST_NW: begin
        if (elem_keep) begin
          tm_we    = 1'b1;
          kept_nxt = kept_r + FW'(1);
        end
        if (elem_counts) begin
          cnt_nxt = cnt_r + FW'(1);
        end
        src_nxt   = src_r + SW'(1);
        rem_nxt   = rem_r - FW'(1);
        state_nxt = (state_r == S_HIST_NW) ? S_COMMIT : S_HIST_RD;
      end
      S_COMMIT: begin
        key_we        = 1'b1;
        key_waddr     = free_r;
        pend_ban_nxt  = ({{(9 - FW){1'b0}}, cnt_r} >= {1'b0, failure_limit});
        key_wdata     = pend_ban_nxt ? {{FW{1'b0}}, 1'b0, ip_r} : {kept_r, 1'b1, ip_r};
        pend_cnt_nxt  = 9'(cnt_r);
        pend_drop_nxt = 1'b0;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || res_ready) begin
          ovalid_nxt = 1'b1;
          oban_nxt   = pend_ban_r;
          ocnt_nxt   = pend_cnt_r;
          odrop_nxt  = pend_drop_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r      <= free_nxt;
    have_free_r <= have_free_nxt;
    ip_r        <= ip_nxt;
    now_r       <= now_nxt;
    base_r      <= base_nxt;
    src_r       <= src_nxt;
    rem_r       <= rem_nxt;
    kept_r      <= kept_nxt;
    cnt_r       <= cnt_nxt;
    filt_r      <= filt_nxt;
    pend_ban_r  <= pend_ban_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    pend_drop_r <= pend_drop_nxt;
    oban_r      <= oban_nxt;
    ocnt_r      <= ocnt_nxt;
    odrop_r     <= odrop_nxt;
  end

  assign status.clearing = (state_r == S_CLEAR);
  assign res_valid       = ovalid_r;
  assign res_ban         = oban_r;
  assign res_recent      = ocnt_r;
  assign res_dropped     = odrop_r;

endmodule

FILE: rtl/failed_attempt_window_tracker.sv
// ----------------------------------------------------------------------------
// failed_attempt_window_tracker: sliding-window failure counter per IPv4 address
// Tracks recent failed attempts per address and requests a ban at the limit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   in_*      input      tdata[31:0] ip_address, tdata[63:32] now_seconds
//   out_*     output     tdata[0] ban_request, [9:1] recent_failures,
//                        [10] dropped_table_full, [15:11] zero
//   cfg_*     input      index 0 failure_limit, index 1 find_window
//
// One request is taken from the queue, then the table is scanned entry by
// entry (a registered RAM read and a compare) up to the matching entry, or
// over the whole table for a new address. It then walks its stored times
// (all but the oldest when the history is full) and goes on to the new time,
// the write-back and the output register. A dropped request skips the walk.
// After reset a clearing pass over every table entry empties the table;
// no request is taken during it, while configuration writes are.
// A two-entry queue takes requests while the engine works, and a finished
// result waits in the output register without stopping the next lookup.
//
module failed_attempt_window_tracker
  import fawt_pkg::*;
#(
  parameter int TRACKED_ADDRESSES = DEF_TRACKED_ADDRESSES,
  parameter int HISTORY_DEPTH     = DEF_HISTORY_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // ip_address, now_seconds
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // ban_request, recent_failures,
                                            // dropped_table_full, zero pad
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]  limit_r, limit_nxt;
  logic [31:0] window_r, window_nxt;

  logic        q_push_ready;
  logic        q_pop_valid;
  logic        q_pop_ready;
  logic [63:0] q_pop_data;

  eng_status_t eng_status;
  logic        res_ban;
  logic [8:0]  res_recent;
  logic        res_dropped;

  // Configuration registers take a write at any edge the enable is high;
  // indexes beyond the register list are ignored.
  always_comb begin
    limit_nxt  = limit_r;
    window_nxt = window_r;
    if (cfg_wr_en) begin
      if (cfg_index == CFG_FAILURE_LIMIT) begin
        limit_nxt = cfg_wdata[7:0];
      end else if (cfg_index == CFG_FIND_WINDOW) begin
        window_nxt = cfg_wdata[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      window_r <= WINDOW_RESET;
    end else begin
      limit_r  <= limit_nxt;
      window_r <= window_nxt;
    end
  end

  // Requests are held off while the table is being cleared after reset.
  assign in_tready = q_push_ready && !eng_status.clearing;

  fawt_queue #(.WIDTH(64)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid && !eng_status.clearing),
    .push_ready (q_push_ready),
    .push_data  (in_tdata),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  fawt_engine #(
    .TRACKED_ADDRESSES (TRACKED_ADDRESSES),
    .HISTORY_DEPTH     (HISTORY_DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (q_pop_valid),
    .req_ready     (q_pop_ready),
    .req_ip        (q_pop_data[31:0]),
    .req_now       (q_pop_data[63:32]),
    .failure_limit (limit_r),
    .find_window   (window_r),
    .status        (eng_status),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_ban       (res_ban),
    .res_recent    (res_recent),
    .res_dropped   (res_dropped)
  );

  assign out_tdata = {5'b0, res_dropped, res_recent, res_ban};

endmodule
